FILE: rtl/nnpr_pkg.sv
package nnpr_pkg;

  localparam int unsigned SAMPLE_W = 8;
  localparam int unsigned PHASE_W = 32;
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;

  localparam logic [PHASE_W-1:0] STEP_RESET = 32'h8000_0000;
  localparam logic [PHASE_W-1:0] MIN_INTERP_STEP = 32'h0400_0000;
  localparam int unsigned MAX_RUN = 64;
  localparam int unsigned RUN_CNT_W = $clog2(MAX_RUN);
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic REG_PHASE_STEP = 1'b0;
  localparam logic REG_INTERP_MODE = 1'b1;

  localparam logic MODE_DECIMATE = 1'b0;
  localparam logic MODE_INTERPOLATE = 1'b1;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] in_i;
    logic signed [SAMPLE_W-1:0] in_q;
  } in_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] out_i;
    logic signed [SAMPLE_W-1:0] out_q;
    logic run_last;
  } out_t;

  typedef struct packed {
    logic mode;
    logic [PHASE_W-1:0] step;
    logic signed [SAMPLE_W-1:0] s_i;
    logic signed [SAMPLE_W-1:0] s_q;
  } job_t;

  typedef enum logic {
    ENG_IDLE,
    ENG_RUN
  } eng_state_t;

endpackage

FILE: rtl/nnpr_front.sv
module nnpr_front #(
  parameter int unsigned QueueDepth = nnpr_pkg::QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  nnpr_pkg::in_t in_data,
  input  logic [nnpr_pkg::PHASE_W-1:0] phase_step,
  input  logic interp_mode,
  output logic job_valid,
  output nnpr_pkg::job_t job,
  input  logic job_pop
);
  import nnpr_pkg::*;

  localparam int unsigned PtrW = $clog2(QueueDepth);
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  job_t queue [QueueDepth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic push;
  logic pop;
  job_t new_job;

  always_comb begin
    new_job.mode = interp_mode;
    new_job.step = phase_step;
    if (interp_mode == MODE_INTERPOLATE && phase_step < MIN_INTERP_STEP) begin
      new_job.step = MIN_INTERP_STEP;
    end
    new_job.s_i = in_data.in_i;
    new_job.s_q = in_data.in_q;
  end

  assign in_ready = (count != CntW'(QueueDepth));
  assign job_valid = (count != '0);
  assign job = queue[rd_ptr];
  assign push = in_valid && in_ready;
  assign pop = job_pop && job_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= new_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10: count <= count + 1'b1;
        2'b01: count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: rtl/nnpr_back.sv
module nnpr_back (
  input  logic clk,
  input  logic rst,
  input  logic job_valid,
  input  nnpr_pkg::job_t job,
  output logic job_pop,
  output logic out_valid,
  input  logic out_ready,
  output nnpr_pkg::out_t out_data
);
  import nnpr_pkg::*;

  eng_state_t state;
  eng_state_t state_next;
  logic [PHASE_W-1:0] phase_acc;
  logic [PHASE_W-1:0] phase_acc_next;
  logic [PHASE_W-1:0] prev_phase;
  logic [PHASE_W-1:0] prev_phase_next;
  logic seen_first;
  logic seen_first_next;
  job_t cur;
  job_t cur_next;
  logic pend;
  logic pend_next;
  logic [RUN_CNT_W-1:0] run_cnt;
  logic [RUN_CNT_W-1:0] run_cnt_next;

  logic slot_free;
  logic [PHASE_W-1:0] step_sel;
  logic [PHASE_W-1:0] phase_sum;
  logic wrap;
  logic emit;
  out_t emit_data;

  assign slot_free = !out_valid || out_ready;
  assign step_sel = (state == ENG_RUN) ? cur.step : job.step;
  assign phase_sum = phase_acc + step_sel;
  assign wrap = (phase_sum <= phase_acc);

  always_comb begin
    state_next = state;
    phase_acc_next = phase_acc;
    prev_phase_next = prev_phase;
    seen_first_next = seen_first;
    cur_next = cur;
    pend_next = pend;
    run_cnt_next = run_cnt;
    job_pop = 1'b0;
    emit = 1'b0;
    emit_data.out_i = cur.s_i;
    emit_data.out_q = cur.s_q;
    emit_data.run_last = 1'b0;
    case (state)
      ENG_IDLE: begin
        if (job_valid && slot_free) begin
          job_pop = 1'b1;
          seen_first_next = 1'b1;
          if (job.mode == MODE_DECIMATE) begin
            emit = (phase_acc <= prev_phase);
            emit_data.out_i = job.s_i;
            emit_data.out_q = job.s_q;
            emit_data.run_last = 1'b1;
            prev_phase_next = phase_acc;
            phase_acc_next = phase_sum;
          end else begin
            cur_next = job;
            pend_next = seen_first;
            run_cnt_next = '0;
            state_next = ENG_RUN;
          end
        end
      end
      ENG_RUN: begin
        if (slot_free) begin
          if (pend && run_cnt == RUN_CNT_W'(MAX_RUN - 1)) begin
            emit = 1'b1;
            emit_data.run_last = 1'b1;
            state_next = ENG_IDLE;
          end else begin
            prev_phase_next = phase_acc;
            phase_acc_next = phase_sum;
            if (pend) begin
              emit = 1'b1;
              emit_data.run_last = wrap;
              if (wrap) begin
                state_next = ENG_IDLE;
              end else begin
                run_cnt_next = run_cnt + 1'b1;
              end
            end else if (wrap) begin
              state_next = ENG_IDLE;
            end else begin
              pend_next = 1'b1;
            end
          end
        end
      end
      default: state_next = ENG_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ENG_IDLE;
      phase_acc <= '0;
      prev_phase <= '0;
      seen_first <= 1'b0;
      pend <= 1'b0;
      run_cnt <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      phase_acc <= phase_acc_next;
      prev_phase <= prev_phase_next;
      seen_first <= seen_first_next;
      pend <= pend_next;
      run_cnt <= run_cnt_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur <= cur_next;
    if (emit) begin
      out_data <= emit_data;
    end
  end

endmodule

FILE: rtl/nearest_neighbor_phase_resampler_top.sv
// Nearest-neighbor resampler for complex 8-bit I/Q samples, steered by a 32-bit
// phase accumulator whose wrap marks sample boundaries.
// Input samples arrive on in_valid/in_ready with in_data, and output samples
// leave on out_valid/out_ready with out_data; run_last flags the final output
// produced by one input request.
// The APB port sets the phase step at address 0 and the mode at address 4.
// Write both registers only while no request is in flight; the block won't check.
// An accepted request enters a two-entry queue, and the engine behind it updates
// the accumulator and loads the output register; in interpolation the engine
// first loads the request into its run state before any output.
// Decimation processes one input per cycle while the output is not stalled,
// limited by the single accumulator add and compare each cycle.
// Interpolation loads the input, then steps the accumulator and emits output
// copies until it wraps or reaches MAX_RUN copies, taking no new input meanwhile.
// A stalled receiver holds the output register and freezes the engine, and once
// the queue fills, in_ready falls.
// Reset clears the accumulator, the queue and the output valid flag, and returns
// the step to one half and the mode to decimation.
module nearest_neighbor_phase_resampler_top #(
  parameter int unsigned QueueDepth = nnpr_pkg::QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  nnpr_pkg::in_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output nnpr_pkg::out_t out_data,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [nnpr_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [nnpr_pkg::APB_DATA_W-1:0] pwdata,
  output logic [nnpr_pkg::APB_DATA_W-1:0] prdata,
  output logic pready
);
  import nnpr_pkg::*;

  logic [PHASE_W-1:0] phase_step;
  logic interp_mode;
  logic reg_sel;
  logic cfg_write;
  logic job_valid;
  job_t job;
  logic job_pop;

  assign pready = 1'b1;
  assign reg_sel = paddr[2];
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata = (reg_sel == REG_INTERP_MODE) ? {{(APB_DATA_W-1){1'b0}}, interp_mode}
                                               : phase_step;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_step <= STEP_RESET;
      interp_mode <= MODE_DECIMATE;
    end else if (cfg_write) begin
      if (reg_sel == REG_PHASE_STEP) begin
        phase_step <= pwdata;
      end else begin
        interp_mode <= pwdata[0];
      end
    end
  end

  nnpr_front #(
    .QueueDepth(QueueDepth)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .phase_step(phase_step),
    .interp_mode(interp_mode),
    .job_valid(job_valid),
    .job(job),
    .job_pop(job_pop)
  );

  nnpr_back u_back (
    .clk(clk),
    .rst(rst),
    .job_valid(job_valid),
    .job(job),
    .job_pop(job_pop),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

endmodule

FILE: rtl/nnpr_checker.sv
module nnpr_checker (
  input logic clk,
  input logic rst,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input nnpr_pkg::out_t out_data,
  input logic psel,
  input logic pready
);

  a_out_hold_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("Output request dropped while stalled.");

  a_out_hold_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_data))
    else $error("Output payload changed while stalled.");

  a_reset_out_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("Output valid after reset.");

  a_reset_in_ready: assert property (@(posedge clk)
    rst |=> in_ready)
    else $error("Input not ready after reset.");

  a_pready_high: assert property (@(posedge clk)
    psel |-> pready)
    else $error("Configuration port inserted a wait state.");

endmodule

bind nearest_neighbor_phase_resampler_top nnpr_checker u_nnpr_checker (.*);
